>>> rtl/core/spf_pkg.sv
package spf_pkg;

  localparam int TABLE_SIZE_DEFAULT = 65536;
  localparam int VALUE_SPAN         = 65536;
  localparam int VALUE_W            = 16;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ONE     = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

endpackage

>>> rtl/core/smallest_prime_factor_factorizer_top.sv
// Channel   Direction  Handshake            Payload
// ------------------------------------------------------------------
// request   in         start && !busy      value[15:0]
// result    out        valid (1 cycle)      factor[15:0], last, status[1:0]
//
// After reset the block stays busy while it builds the smallest-factor table: it first writes
// every entry in turn (TABLE_SIZE capped at 65536), then reads and checks (S_MRD, S_MCHK)
// each odd multiple of each odd prime below the square root.
// Per value: S_IDLE takes the beat, then S_LOOK and S_FCHK look up each factor and also
// emit it when it is 2 or the last prime; any other factor passes the radix-4 divider (S_DIV).
// Zero, one and out-of-range values answer in the cycle after the beat; no stall from out.
module smallest_prime_factor_factorizer_top #(
  parameter int TABLE_SIZE = spf_pkg::TABLE_SIZE_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [spf_pkg::VALUE_W-1:0]  value,
  output logic                         valid,
  output logic [spf_pkg::VALUE_W-1:0]  factor,
  output logic                         last,
  output logic [1:0]                   status
);

  localparam int TBL_DEPTH = (TABLE_SIZE < spf_pkg::VALUE_SPAN) ? TABLE_SIZE
                                                                : spf_pkg::VALUE_SPAN;
  localparam int AW = $clog2(TBL_DEPTH);
  localparam int VW = spf_pkg::VALUE_W;

  typedef enum logic [9:0] {
    S_INIT  = 10'b00_0000_0001,
    S_SQ    = 10'b00_0000_0010,
    S_PTEST = 10'b00_0000_0100,
    S_PCHK  = 10'b00_0000_1000,
    S_MRD   = 10'b00_0001_0000,
    S_MCHK  = 10'b00_0010_0000,
    S_IDLE  = 10'b00_0100_0000,
    S_LOOK  = 10'b00_1000_0000,
    S_FCHK  = 10'b01_0000_0000,
    S_DIV   = 10'b10_0000_0000
  } state_t;

  state_t          state;
  logic [AW:0]     idx;
  logic [AW-1:0]   p;
  logic [2*AW-1:0] psq;
  logic [VW-1:0]   cof;
  logic [VW-1:0]   dvs;
  logic [VW-1:0]   rem;
  logic [VW-1:0]   quo;
  logic [2:0]      cnt;

  logic [AW-1:0]   tbl [TBL_DEPTH];
  logic [AW-1:0]   rdata;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   wdata;
  logic [AW-1:0]   raddr;

  logic [VW-1:0]   pf;
  logic [VW:0]     r1, r2;
  logic            ge1, ge2;
  logic [VW-1:0]   r1s, r2s;
  logic [VW-1:0]   q1, q2;

  assign busy = (state != S_IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = idx[AW-1:0];
    raddr = idx[AW-1:0];
    unique case (state)
      S_INIT: begin
        we = 1'b1;
        if (!idx[0] && idx >= (AW+1)'(4)) begin
          wdata = AW'(2);
        end
      end
      S_PTEST: raddr = p;
      S_MCHK: begin
        we    = (rdata == idx[AW-1:0]);
        wdata = p;
      end
      S_LOOK:  raddr = cof[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tbl[waddr] <= wdata;
    end
    rdata <= tbl[raddr];
  end

  // smallest factor; an entry below two never occurs past the sieve
  assign pf = (VW'(rdata) < VW'(2)) ? cof : VW'(rdata);

  // two restoring steps of the shared divider per cycle
  always_comb begin
    r1  = {rem, quo[VW-1]};
    ge1 = (r1 >= {1'b0, dvs});
    r1s = ge1 ? VW'(r1 - {1'b0, dvs}) : r1[VW-1:0];
    q1  = {quo[VW-2:0], ge1};
    r2  = {r1s, q1[VW-1]};
    ge2 = (r2 >= {1'b0, dvs});
    r2s = ge2 ? VW'(r2 - {1'b0, dvs}) : r2[VW-1:0];
    q2  = {q1[VW-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    valid <= 1'b0;
    if (rst) begin
      state <= S_INIT;
      idx   <= '0;
    end else begin
      unique case (state)
        S_INIT: begin
          idx <= idx + (AW+1)'(1);
          if (idx == (AW+1)'(TBL_DEPTH - 1)) begin
            p     <= AW'(3);
            state <= S_SQ;
          end
        end
        S_SQ: begin
          psq   <= (2*AW)'(p) * (2*AW)'(p);
          state <= S_PTEST;
        end
        S_PTEST: begin
          if (psq >= (2*AW)'(TBL_DEPTH)) begin
            state <= S_IDLE;
          end else begin
            state <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (rdata == p) begin
            idx   <= psq[AW:0];
            state <= S_MRD;
          end else begin
            p     <= p + AW'(2);
            state <= S_SQ;
          end
        end
        S_MRD: begin
          if (idx >= (AW+1)'(TBL_DEPTH)) begin
            p     <= p + AW'(2);
            state <= S_SQ;
          end else begin
            state <= S_MCHK;
          end
        end
        S_MCHK: begin
          // odd multiples only: even entries already hold two
          idx   <= idx + {p, 1'b0};
          state <= S_MRD;
        end
        S_IDLE: begin
          if (start) begin
            if (value == '0 || {1'b0, value} >= (VW+1)'(TBL_DEPTH)) begin
              valid  <= 1'b1;
              factor <= '0;
              last   <= 1'b1;
              status <= spf_pkg::ST_INVALID;
            end else if (value == VW'(1)) begin
              valid  <= 1'b1;
              factor <= '0;
              last   <= 1'b1;
              status <= spf_pkg::ST_ONE;
            end else begin
              cof   <= value;
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: state <= S_FCHK;
        S_FCHK: begin
          dvs <= pf;
          if (pf == cof) begin
            valid  <= 1'b1;
            factor <= pf;
            last   <= 1'b1;
            status <= spf_pkg::ST_OK;
            state  <= S_IDLE;
          end else if (pf == VW'(2)) begin
            valid  <= 1'b1;
            factor <= pf;
            last   <= (cof[VW-1:1] <= (VW-1)'(1));
            status <= spf_pkg::ST_OK;
            cof    <= {1'b0, cof[VW-1:1]};
            state  <= (cof[VW-1:1] <= (VW-1)'(1)) ? S_IDLE : S_LOOK;
          end else begin
            rem   <= '0;
            quo   <= cof;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= r2s;
          quo <= q2;
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            valid  <= 1'b1;
            factor <= dvs;
            last   <= (q2 <= VW'(1));
            status <= spf_pkg::ST_OK;
            cof    <= q2;
            state  <= (q2 <= VW'(1)) ? S_IDLE : S_LOOK;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

endmodule

>>> rtl/core/spf_checker.sv
module spf_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [15:0] value,
  input logic        valid,
  input logic [15:0] factor,
  input logic        last,
  input logic [1:0]  status
);

  a_special_form: assert property (@(posedge clk) disable iff (rst)
    valid && status != spf_pkg::ST_OK |-> last && factor == 16'd0)
    else $error("special result without last mark or with nonzero factor");

  a_factor_prime_range: assert property (@(posedge clk) disable iff (rst)
    valid && status == spf_pkg::ST_OK |-> factor >= 16'd2)
    else $error("ok result with factor below two");

  a_zero_invalid: assert property (@(posedge clk) disable iff (rst)
    start && !busy && value == 16'd0 |=> valid && status == spf_pkg::ST_INVALID)
    else $error("zero value not answered as invalid");

  a_one_answer: assert property (@(posedge clk) disable iff (rst)
    start && !busy && value == 16'd1 |=> valid && last && status == spf_pkg::ST_ONE)
    else $error("value one not answered with the no-factor result");

  a_idle_means_last: assert property (@(posedge clk) disable iff (rst)
    valid && !busy && status == spf_pkg::ST_OK |-> last)
    else $error("block went idle before the final factor");

endmodule

bind smallest_prime_factor_factorizer_top spf_checker u_spf_checker (.*);

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W     = spf_pkg::VALUE_W;
  localparam int VALUE_SPAN  = spf_pkg::VALUE_SPAN;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [VALUE_W-1:0] factor;
    logic               last;
    spf_pkg::status_t   status;
  } factor_beat_t;

  // Predicts the factor beats of each accepted value and checks them in order.
  class factor_scoreboard;
    bit [VALUE_W-1:0] least_div [0:VALUE_SPAN-1];
    factor_beat_t     due_q[$];
    int               errors;

    function new();
      for (int i = 0; i < VALUE_SPAN; i++) least_div[i] = '0;
      for (int i = 2; i < VALUE_SPAN; i++) begin
        if (least_div[i] == 0) begin
          least_div[i] = VALUE_W'(i);
          if (i < 256) begin
            for (int j = i * i; j < VALUE_SPAN; j += i) begin
              if (least_div[j] == 0) least_div[j] = VALUE_W'(i);
            end
          end
        end
      end
      errors = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void queue_beat(factor_beat_t b);
      due_q = {due_q, b};
    endfunction

    task flag_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    function void note_value(logic [VALUE_W-1:0] v);
      factor_beat_t b;
      int           rest;
      int           p;
      if (v == 0) begin
        b = '{factor: '0, last: 1'b1, status: spf_pkg::ST_INVALID};
        queue_beat(b);
      end else if (v == 1) begin
        b = '{factor: '0, last: 1'b1, status: spf_pkg::ST_ONE};
        queue_beat(b);
      end else begin
        rest = v;
        while (rest > 1) begin
          p = least_div[rest];
          rest = rest / p;
          b = '{factor: p[VALUE_W-1:0], last: (rest == 1), status: spf_pkg::ST_OK};
          queue_beat(b);
        end
      end
    endfunction

    task check_factor(logic [VALUE_W-1:0] f, logic l, logic [1:0] s);
      factor_beat_t want;
      if (due_q.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: factor=%0d last=%0b status=%0d",
                                f, l, s));
      end else begin
        want = due_q.pop_front();
        if (f !== want.factor)
          flag_mismatch($sformatf("factor got %0d want %0d", f, want.factor));
        if (l !== want.last)
          flag_mismatch($sformatf("last got %0b want %0b (factor %0d)", l, want.last,
                                  want.factor));
        if (s !== want.status)
          flag_mismatch($sformatf("status got %0d want %0d", s, want.status));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [VALUE_W-1:0] value = '0;
  logic               busy;
  logic               valid;
  logic [VALUE_W-1:0] factor;
  logic               last;
  logic [1:0]         status;

  factor_scoreboard sb = new();
  int               cycles = 0;

  smallest_prime_factor_factorizer_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .value  (value),
    .valid  (valid),
    .factor (factor),
    .last   (last),
    .status (status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL smallest_prime_factor_factorizer_top");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && valid) sb.check_factor(factor, last, status);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int small_primes[11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
    int power_bases[8] = '{2, 3, 5, 7, 17, 251, 255, 257};
    int r;
    int acc;
    int p;
    r = $urandom_range(0, 99);
    if (r < 30) return VALUE_W'($urandom_range(0, 65535));
    if (r < 42) return VALUE_W'($urandom_range(0, 40));
    if (r < 72) begin
      // product of up to 16 small primes, stopping at random and kept within 16 bits
      acc = 1;
      for (int k = 0; k < 16; k++) begin
        p = small_primes[$urandom_range(0, 10)];
        if (acc * p > 65535) break;
        acc = acc * p;
        if ($urandom_range(0, 9) == 0) break;
      end
      return VALUE_W'(acc);
    end
    if (r < 86) begin
      acc = 1;
      p = power_bases[$urandom_range(0, 7)];
      while (acc * p <= 65535 && $urandom_range(0, 5) != 0) acc = acc * p;
      if (acc == 1) acc = p;
      return VALUE_W'(acc);
    end
    // a prime, often a large one
    acc = $urandom_range(2, 65535);
    while (sb.least_div[acc] != acc) acc--;
    return VALUE_W'(acc);
  endfunction

  // Hold start until the beat is taken; start stays up if the next call has no gap.
  task send_value(logic [VALUE_W-1:0] v, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      value <= VALUE_W'($urandom_range(0, 65535));
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    sb.note_value(v);
  endtask

  task wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [VALUE_W-1:0] directed[$];
    int                 burst;
    directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd7, 16'd9, 16'd65535,
                 16'd65521, 16'd32768, 16'd65534, 16'd49152, 16'd59049, 16'd65025,
                 16'd30030, 16'd63001, 16'd4096, 16'd65532, 16'd1, 16'd0, 16'd43691};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_value(directed[i], (i % 3 == 0) ? 0 : pick_gap());
    wait_drained();

    burst = 0;
    for (int n = 0; n < 390; n++) begin
      if (n % 130 == 129) wait_drained();
      if (burst == 0 && $urandom_range(0, 19) == 0) burst = $urandom_range(8, 25);
      if (burst > 0) begin
        burst--;
        send_value(pick_value(), 0);
      end else begin
        send_value(pick_value(), pick_gap());
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS smallest_prime_factor_factorizer_top");
    end else begin
      $display("FAIL smallest_prime_factor_factorizer_top");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/spf_pkg.sv
rtl/core/smallest_prime_factor_factorizer_top.sv
rtl/core/spf_checker.sv
tb/tb.sv
